>>> src/qoc_pkg.sv
// ----------------------------------------------------------------------------
// qoc_pkg
// Shared types and constants of the quaternion offset corrector.
// ----------------------------------------------------------------------------
`default_nettype none
package qoc_pkg;

   localparam int unsigned UNIT_SCALE = 10000;
   // 4 * UNIT_SCALE^2, right side factor of the rounding test
   localparam logic [31:0] RND_K = 32'd400000000;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DESIRED_W = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DESIRED_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DESIRED_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DESIRED_Z = 2'd3;

   // term (k, j) of the Hamilton product is a[j] * b[k ^ j];
   // bit 4*k + j set means the term is subtracted
   localparam logic [15:0] TERM_NEG = 16'b0100_0010_1000_1110;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_SQ,
      ST_SDRAIN,
      ST_ZCHK,
      ST_KLO,
      ST_KHI,
      ST_INIT,
      ST_CHK,
      ST_T2,
      ST_LHI,
      ST_CMP,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

>>> src/qoc_ifs.sv
// ----------------------------------------------------------------------------
// qoc_ifs
// Channel interfaces: sample request, result response, register write.
// ----------------------------------------------------------------------------
`default_nettype none
interface qoc_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] q_w;
   logic signed [15:0] q_x;
   logic signed [15:0] q_y;
   logic signed [15:0] q_z;
   modport source (output valid, mode, q_w, q_x, q_y, q_z, input ready);
   modport sink (input valid, mode, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qoc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] out_w;
   logic signed [14:0] out_x;
   logic signed [14:0] out_y;
   logic signed [14:0] out_z;
   logic               zero_norm;
   modport source (output valid, out_w, out_x, out_y, out_z, zero_norm, input ready);
   modport sink (input valid, out_w, out_x, out_y, out_z, zero_norm, output ready);
endinterface

interface qoc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [qoc_pkg::CSR_IDX_W-1:0]       index;
   logic signed [14:0]                  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/qoc_mul.sv
// ----------------------------------------------------------------------------
// qoc_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module qoc_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

>>> src/quaternion_offset_corrector.sv
// ----------------------------------------------------------------------------
// quaternion_offset_corrector
// Sequence: after acceptance the product and norm are formed, then per
//   component the rounding bound is set up and a search of 13 or 14 steps
//   runs before the result is loaded; a zero norm skips the search.
// Throughput: one transaction at a time, ready again the cycle after the
//   result is loaded; one 32x32 multiplier serves every product and test.
// Reset: synchronous; desired quaternion and offset return to identity.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_offset_corrector (
   input wire logic   clock,
   input wire logic   reset,
   qoc_req_if.sink    req_bus,
   qoc_rsp_if.source  rsp_bus,
   qoc_csr_if.sink    csr_bus
);
   qoc_pkg::state_type state_ff, state_in;

   logic [3:0]         cnt_ff, cnt_in;
   logic               mode_ff, mode_in;
   logic signed [15:0] a_ff [4];
   logic signed [15:0] a_in [4];
   logic signed [16:0] b_ff [4];
   logic signed [16:0] b_in [4];
   logic signed [34:0] p_ff [4];
   logic signed [34:0] p_in [4];
   logic [63:0]        sq_ff [4];
   logic [63:0]        sq_in [4];
   logic [63:0]        s_ff, s_in;
   logic [95:0]        rhs_ff, rhs_in;
   logic [63:0]        lhs_ff, lhs_in;
   logic [31:0]        t2_ff, t2_in;
   logic [13:0]        lo_ff, lo_in;
   logic [13:0]        hi_ff, hi_in;
   logic [13:0]        mid_ff, mid_in;
   logic [1:0]         comp_ff, comp_in;
   logic signed [15:0] res_ff [4];
   logic signed [15:0] res_in [4];
   logic               zn_ff, zn_in;
   logic signed [15:0] desired_ff [4];
   logic signed [15:0] desired_in [4];
   logic signed [15:0] offset_ff [4];
   logic signed [15:0] offset_in [4];

   // product pipeline tags: what the multiplier output belongs to
   logic               acc_vld_ff, acc_vld_in;
   logic [1:0]         acc_k_ff, acc_k_in;
   logic               acc_neg_ff, acc_neg_in;
   logic               sq_vld_ff, sq_vld_in;
   logic [1:0]         sq_k_ff, sq_k_in;

   logic               out_vld_ff, out_vld_in;
   logic signed [14:0] out_ff [4];
   logic signed [14:0] out_in [4];
   logic               out_zn_ff, out_zn_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;
   logic signed [15:0] q_arr [4];

   qoc_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(prod));

   assign q_arr[0] = req_bus.q_w;
   assign q_arr[1] = req_bus.q_x;
   assign q_arr[2] = req_bus.q_y;
   assign q_arr[3] = req_bus.q_z;

   assign req_bus.ready  = (state_ff == qoc_pkg::ST_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign rsp_bus.valid  = out_vld_ff;
   assign rsp_bus.out_w  = out_ff[0];
   assign rsp_bus.out_x  = out_ff[1];
   assign rsp_bus.out_y  = out_ff[2];
   assign rsp_bus.out_z  = out_ff[3];
   assign rsp_bus.zero_norm = out_zn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= qoc_pkg::ST_IDLE;
         acc_vld_ff <= 1'b0;
         sq_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         desired_ff[0] <= 16'sd10000;
         offset_ff[0]  <= 16'sd10000;
         for (int i = 1; i < 4; i++) begin
            desired_ff[i] <= '0;
            offset_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         acc_vld_ff <= acc_vld_in;
         sq_vld_ff  <= sq_vld_in;
         out_vld_ff <= out_vld_in;
         desired_ff <= desired_in;
         offset_ff  <= offset_in;
      end
      cnt_ff    <= cnt_in;
      mode_ff   <= mode_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      p_ff      <= p_in;
      sq_ff     <= sq_in;
      s_ff      <= s_in;
      rhs_ff    <= rhs_in;
      lhs_ff    <= lhs_in;
      t2_ff     <= t2_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      comp_ff   <= comp_in;
      res_ff    <= res_in;
      zn_ff     <= zn_in;
      acc_k_ff  <= acc_k_in;
      acc_neg_ff <= acc_neg_in;
      sq_k_ff   <= sq_k_in;
      out_ff    <= out_in;
      out_zn_ff <= out_zn_in;
   end

   always_comb begin
      logic [1:0]  tj, tk, tb;
      logic [15:0] a_mag, b_mag;
      logic [34:0] term;
      logic [31:0] p_mag;
      logic [14:0] mid_sum;
      logic [13:0] mid_v;
      logic [14:0] t_v;
      logic [95:0] lhs_full;

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      p_in       = p_ff;
      sq_in      = sq_ff;
      s_in       = s_ff;
      rhs_in     = rhs_ff;
      lhs_in     = lhs_ff;
      t2_in      = t2_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      comp_in    = comp_ff;
      res_in     = res_ff;
      zn_in      = zn_ff;
      desired_in = desired_ff;
      offset_in  = offset_ff;
      acc_vld_in = 1'b0;
      acc_k_in   = acc_k_ff;
      acc_neg_in = acc_neg_ff;
      sq_vld_in  = 1'b0;
      sq_k_in    = sq_k_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      out_zn_in  = out_zn_ff;
      mul_a      = '0;
      mul_b      = '0;
      tj = '0; tk = '0; tb = '0;
      a_mag = '0; b_mag = '0; p_mag = '0;
      mid_sum = '0; mid_v = '0; t_v = '0; lhs_full = '0;
      term = {3'b000, prod[31:0]};

      // register writes, only while idle: the user must keep to this, the block does not enforce it
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            qoc_pkg::REG_DESIRED_W: desired_in[0] = 16'(csr_bus.data);
            qoc_pkg::REG_DESIRED_X: desired_in[1] = 16'(csr_bus.data);
            qoc_pkg::REG_DESIRED_Y: desired_in[2] = 16'(csr_bus.data);
            qoc_pkg::REG_DESIRED_Z: desired_in[3] = 16'(csr_bus.data);
         endcase
      end

      // retire multiplier results in the cycle after issue
      if (acc_vld_ff) begin
         p_in[acc_k_ff] = acc_neg_ff ? p_ff[acc_k_ff] - $signed(term)
                                     : p_ff[acc_k_ff] + $signed(term);
      end
      if (sq_vld_ff) begin
         sq_in[sq_k_ff] = prod;
         s_in = s_ff + prod;
      end

      if (out_vld_ff && rsp_bus.ready) out_vld_in = 1'b0;

      unique case (state_ff)
         qoc_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               mode_in = req_bus.mode;
               for (int i = 0; i < 4; i++) begin
                  a_in[i] = req_bus.mode ? desired_ff[i] : offset_ff[i];
                  // calibrate uses the conjugate of the sample
                  b_in[i] = (req_bus.mode && i != 0) ? -17'(q_arr[i])
                                                     : 17'(q_arr[i]);
                  p_in[i] = '0;
               end
               s_in     = '0;
               cnt_in   = '0;
               state_in = qoc_pkg::ST_PROD;
            end
         end
         qoc_pkg::ST_PROD: begin
            tj = cnt_ff[1:0];
            tk = cnt_ff[3:2];
            tb = tk ^ tj;
            a_mag = a_ff[tj][15] ? 16'(-a_ff[tj]) : 16'(a_ff[tj]);
            b_mag = b_ff[tb][16] ? 16'(-b_ff[tb]) : 16'(b_ff[tb]);
            mul_a = {16'b0, a_mag};
            mul_b = {16'b0, b_mag};
            acc_vld_in = 1'b1;
            acc_k_in   = tk;
            acc_neg_in = a_ff[tj][15] ^ b_ff[tb][16] ^ qoc_pkg::TERM_NEG[cnt_ff];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = qoc_pkg::ST_SQ;
         end
         qoc_pkg::ST_SQ: begin
            p_mag = p_ff[cnt_ff[1:0]][34] ? 32'(-p_ff[cnt_ff[1:0]])
                                          : 32'(p_ff[cnt_ff[1:0]]);
            mul_a = p_mag;
            mul_b = p_mag;
            sq_vld_in = 1'b1;
            sq_k_in   = cnt_ff[1:0];
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff[1:0] == 2'd3) state_in = qoc_pkg::ST_SDRAIN;
         end
         qoc_pkg::ST_SDRAIN: state_in = qoc_pkg::ST_ZCHK;
         qoc_pkg::ST_ZCHK: begin
            comp_in = '0;
            if (s_ff == '0) begin
               // zero product goes out unchanged and flagged
               zn_in = 1'b1;
               for (int i = 0; i < 4; i++) res_in[i] = '0;
               state_in = qoc_pkg::ST_FIN;
            end else begin
               zn_in = 1'b0;
               state_in = qoc_pkg::ST_KLO;
            end
         end
         qoc_pkg::ST_KLO: begin
            mul_a = qoc_pkg::RND_K;
            mul_b = sq_ff[comp_ff][31:0];
            state_in = qoc_pkg::ST_KHI;
         end
         qoc_pkg::ST_KHI: begin
            mul_a = qoc_pkg::RND_K;
            mul_b = sq_ff[comp_ff][63:32];
            rhs_in = {32'b0, prod};
            state_in = qoc_pkg::ST_INIT;
         end
         qoc_pkg::ST_INIT: begin
            rhs_in = rhs_ff + {prod, 32'b0};
            lo_in  = '0;
            hi_in  = 14'(qoc_pkg::UNIT_SCALE);
            state_in = qoc_pkg::ST_CHK;
         end
         qoc_pkg::ST_CHK: begin
            if (lo_ff < hi_ff) begin
               mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 15'd1;
               mid_v   = mid_sum[14:1];
               t_v     = {mid_v, 1'b0} - 15'd1;
               mul_a   = {17'b0, t_v};
               mul_b   = {17'b0, t_v};
               mid_in  = mid_v;
               state_in = qoc_pkg::ST_T2;
            end else begin
               res_in[comp_ff] = p_ff[comp_ff][34] ? -16'({2'b00, lo_ff})
                                                   : 16'({2'b00, lo_ff});
               comp_in = comp_ff + 2'd1;
               state_in = (comp_ff == 2'd3) ? qoc_pkg::ST_FIN : qoc_pkg::ST_KLO;
            end
         end
         qoc_pkg::ST_T2: begin
            t2_in = prod[31:0];
            mul_a = prod[31:0];
            mul_b = s_ff[31:0];
            state_in = qoc_pkg::ST_LHI;
         end
         qoc_pkg::ST_LHI: begin
            mul_a  = t2_ff;
            mul_b  = s_ff[63:32];
            lhs_in = prod;
            state_in = qoc_pkg::ST_CMP;
         end
         qoc_pkg::ST_CMP: begin
            // (2*mid-1)^2 * s against 4*10000^2 * p^2
            lhs_full = {32'b0, lhs_ff} + {prod, 32'b0};
            if (lhs_full <= rhs_ff) lo_in = mid_ff;
            else hi_in = mid_ff - 14'd1;
            state_in = qoc_pkg::ST_CHK;
         end
         qoc_pkg::ST_FIN: begin
            if (!out_vld_ff || rsp_bus.ready) begin
               out_vld_in = 1'b1;
               out_zn_in  = zn_ff;
               for (int i = 0; i < 4; i++) begin
                  out_in[i] = res_ff[i][14:0];
                  if (mode_ff) offset_in[i] = res_ff[i];
               end
               state_in = qoc_pkg::ST_IDLE;
            end
         end
         default: state_in = qoc_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.zero_norm |->
         rsp_bus.out_w == 0 && rsp_bus.out_x == 0 &&
         rsp_bus.out_y == 0 && rsp_bus.out_z == 0)
      else $error("zero_norm result with nonzero component");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.out_w <= 15'sd10000 && rsp_bus.out_w >= -15'sd10000 &&
         rsp_bus.out_x <= 15'sd10000 && rsp_bus.out_x >= -15'sd10000)
      else $error("result component out of range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("ready right after a transaction");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quaternion_offset_corrector. Drives correct and
// calibrate transactions, predicts every normalized result from a local
// integer model of the Hamilton product and exact rounding, and compares
// each response field by field under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_CORRECT   = 1'b0;
   localparam logic MODE_CALIBRATE = 1'b1;
   // Idle cycles with no transaction on any channel before giving up.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;
   localparam int RANDOM_ITEMS   = 185;   // per idle phase, four phases

   typedef struct packed {
      logic signed [14:0] w;
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic signed [14:0] z;
      logic               zero_norm;
   } quat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qoc_req_if req_if ();
   qoc_rsp_if rsp_if ();
   qoc_csr_if csr_if ();

   quaternion_offset_corrector DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Local copy of the block state: desired quaternion and stored offset
   // ------------------------------------------------------------------
   longint desired_q [4];
   longint offset_q  [4];

   quat_result_type pending_results [$];

   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int zero_count    = 0;
   int cal_count     = 0;
   int src_idle_pct  = 0;
   int sink_stall_pct = 0;

   // round(c * 10000 / sqrt(s)), ties away from zero, exact
   function automatic longint normalize_part(longint c, longint unsigned s);
      longint unsigned mag_c, lo, hi, mid, t;
      logic [127:0]    lhs, rhs, tt, ss, kk, aa;
      mag_c = (c < 0) ? longint'(-c) : longint'(c);
      kk = 128'(qoc_pkg::RND_K);
      aa = 128'(mag_c * mag_c);
      rhs = kk * aa;
      ss = 128'(s);
      lo = 0;
      hi = qoc_pkg::UNIT_SCALE;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         t = 2 * mid - 1;
         tt = 128'(t * t);
         lhs = tt * ss;
         if (lhs <= rhs)
            lo = mid;
         else
            hi = mid - 1;
      end
      return (c < 0) ? -longint'(lo) : longint'(lo);
   endfunction

   // Hamilton product of the held operand with the sample, then normalize.
   // Calibrate uses desired * conj(sample) and keeps the result as offset.
   function automatic quat_result_type predict_quat(logic mode, logic signed [15:0] qw,
                                                    logic signed [15:0] qx,
                                                    logic signed [15:0] qy,
                                                    logic signed [15:0] qz);
      longint a [4];
      longint b [4];
      longint p [4];
      longint unsigned s;
      quat_result_type r;
      b[0] = qw; b[1] = qx; b[2] = qy; b[3] = qz;
      if (mode == MODE_CALIBRATE) begin
         a = desired_q;
         b[1] = -b[1]; b[2] = -b[2]; b[3] = -b[3];
      end else begin
         a = offset_q;
      end
      p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
      s = 0;
      for (int i = 0; i < 4; i++)
         s += longint'(p[i] * p[i]);
      if (s == 0) begin
         for (int i = 0; i < 4; i++)
            p[i] = 0;
         r.zero_norm = 1'b1;
      end else begin
         for (int i = 0; i < 4; i++)
            p[i] = normalize_part(p[i], s);
         r.zero_norm = 1'b0;
      end
      if (mode == MODE_CALIBRATE)
         offset_q = p;
      r.w = p[0][14:0];
      r.x = p[1][14:0];
      r.y = p[2][14:0];
      r.z = p[3][14:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      error_count++;
      $display("[%0t] MISMATCH rsp #%0d %s: got %0d expected %0d",
               $realtime, checked_count, field, got, want);
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure and in-order compare
   // ------------------------------------------------------------------
   initial rsp_if.ready = 1'b0;

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      quat_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("[%0t] UNEXPECTED response transaction", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.out_w !== want.w) report_mismatch("out_w", rsp_if.out_w, want.w);
            if (rsp_if.out_x !== want.x) report_mismatch("out_x", rsp_if.out_x, want.x);
            if (rsp_if.out_y !== want.y) report_mismatch("out_y", rsp_if.out_y, want.y);
            if (rsp_if.out_z !== want.z) report_mismatch("out_z", rsp_if.out_z, want.z);
            if (rsp_if.zero_norm !== want.zero_norm)
               report_mismatch("zero_norm", rsp_if.zero_norm, want.zero_norm);
            if (want.zero_norm) zero_count++;
            checked_count++;
         end
      end
   end

   // Watchdog: cycles with no transaction on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding",
                  pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_sample(logic mode, logic signed [15:0] qw, logic signed [15:0] qx,
                              logic signed [15:0] qy, logic signed [15:0] qz);
      int gap;
      gap = 0;
      while ($urandom_range(99) < src_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.q_w   <= qw;
      req_if.q_x   <= qx;
      req_if.q_y   <= qy;
      req_if.q_z   <= qz;
      do @(posedge clock); while (!req_if.ready);
      // transaction accepted at this edge; state advances in order
      pending_results.push_back(predict_quat(mode, qw, qx, qy, qz));
      sent_count++;
      if (mode == MODE_CALIBRATE) cal_count++;
   endtask

   // Hold off the sender until every outstanding result has been checked
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_desired(logic [qoc_pkg::CSR_IDX_W-1:0] idx,
                                logic signed [14:0] value);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      desired_q[idx] = value;
   endtask

   task automatic write_desired_all(logic signed [14:0] w, logic signed [14:0] x,
                                    logic signed [14:0] y, logic signed [14:0] z);
      write_desired(qoc_pkg::REG_DESIRED_W, w);
      write_desired(qoc_pkg::REG_DESIRED_X, x);
      write_desired(qoc_pkg::REG_DESIRED_Y, y);
      write_desired(qoc_pkg::REG_DESIRED_Z, z);
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3, 4, 5: return 16'($signed($urandom_range(20000)) - 10000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [14:0] rand_desired();
      case ($urandom_range(7))
         0: return 15'sh4000;   // most negative pattern
         1: return 15'sh3fff;
         2: return 15'sd10000;
         3: return -15'sd10000;
         4: return 15'sd0;
         5: return 15'($urandom);
         default: return 15'($signed($urandom_range(20000)) - 10000);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // identity offset passes unit quaternions through and normalizes extreme samples
      send_sample(MODE_CORRECT, 16'sd10000, 16'sd0, 16'sd0, 16'sd0);
      send_sample(MODE_CORRECT, 16'sd0, 16'sd0, 16'sd0, -16'sd10000);
      send_sample(MODE_CORRECT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(MODE_CORRECT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(MODE_CORRECT, 16'sh8000, 16'sh7fff, 16'sd1, -16'sd1);
      // small magnitudes exercise rounding
      send_sample(MODE_CORRECT, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
      send_sample(MODE_CORRECT, 16'sd3, -16'sd4, 16'sd0, 16'sd0);
      // calibrate against identity desired, then correct through it
      send_sample(MODE_CALIBRATE, 16'sd7071, 16'sd7071, 16'sd0, 16'sd0);
      send_sample(MODE_CORRECT, 16'sd7071, 16'sd7071, 16'sd0, 16'sd0);
      send_sample(MODE_CORRECT, 16'sd5000, -16'sd5000, 16'sd5000, -16'sd5000);
      send_sample(MODE_CALIBRATE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(MODE_CORRECT, 16'sd1234, 16'sd2345, -16'sd3456, 16'sd4567);
   endtask

   task automatic test_zero_norm();
      // zero sample in correct mode
      send_sample(MODE_CORRECT, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      // zero sample in calibrate mode stores a zero offset ...
      send_sample(MODE_CALIBRATE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      // ... so every correction reports zero norm until recalibrated
      send_sample(MODE_CORRECT, 16'sd10000, 16'sd0, 16'sd0, 16'sd0);
      send_sample(MODE_CORRECT, 16'sh7fff, 16'sh8000, 16'sd5, -16'sd7);
      send_sample(MODE_CALIBRATE, 16'sd10000, 16'sd0, 16'sd0, 16'sd0);
      send_sample(MODE_CORRECT, 16'sd10000, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_config_extremes();
      // out-of-range register patterns, including zero desired quaternion
      write_desired_all(15'sh4000, 15'sh3fff, 15'sh4000, 15'sh3fff);
      send_sample(MODE_CALIBRATE, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_sample(MODE_CORRECT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      write_desired_all(15'sd0, 15'sd0, 15'sd0, 15'sd0);
      send_sample(MODE_CALIBRATE, 16'sd10000, 16'sd0, 16'sd0, 16'sd0);
      write_desired_all(-15'sd10000, 15'sd10000, -15'sd10000, 15'sd10000);
      send_sample(MODE_CALIBRATE, 16'sd0, 16'sd0, 16'sd10000, 16'sd0);
      send_sample(MODE_CORRECT, 16'sd0, 16'sd10000, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_phase(int src_pct, int sink_pct);
      logic mode;
      logic signed [15:0] c [4];
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      write_desired_all(rand_desired(), rand_desired(), rand_desired(), rand_desired());
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            write_desired(qoc_pkg::CSR_IDX_W'($urandom_range(3)), rand_desired());
         if (n == RANDOM_ITEMS / 3)
            wait_idle();
         mode = ($urandom_range(99) < 20) ? MODE_CALIBRATE : MODE_CORRECT;
         for (int i = 0; i < 4; i++)
            c[i] = rand_comp();
         if ($urandom_range(99) < 4)
            c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
         send_sample(mode, c[0], c[1], c[2], c[3]);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.mode  = MODE_CORRECT;
      req_if.q_w   = '0;
      req_if.q_x   = '0;
      req_if.q_y   = '0;
      req_if.q_z   = '0;
      csr_if.valid = 1'b0;
      csr_if.index = qoc_pkg::REG_DESIRED_W;
      csr_if.data  = '0;
      desired_q = '{10000, 0, 0, 0};
      offset_q  = '{10000, 0, 0, 0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_zero_norm();
      test_config_extremes();
      test_random_phase(0, 0);
      test_random_phase(81, 0);
      test_random_phase(0, 81);
      test_random_phase(26, 26);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", pending_results.size());
      end

      $display("Covered %0d transactions (%0d calibrate, %0d zero norm), %0d checked",
               sent_count, cal_count, zero_count, checked_count);
      $display("Register extremes and four idle/backpressure mixes; %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
